// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/prbp_pkg.sv =====
// Package: field widths, register and device codes, colour conversion.
package prbp_pkg;

  localparam int OFFSET_W   = 2;
  localparam int WORD_W     = 32;
  localparam int RDATA_W    = 16;
  localparam int CINDEX_W   = 11;
  localparam int SEL_W      = 4;

  localparam logic [OFFSET_W-1:0] OFF_ADDR = 2'd0;
  localparam logic [OFFSET_W-1:0] OFF_DATA = 2'd1;
  localparam logic [OFFSET_W-1:0] OFF_SEL  = 2'd2;

  localparam logic MODE_WRITE = 1'b1;

  localparam logic [SEL_W-1:0] DEV_PALETTE = 4'hd;
  localparam logic [SEL_W-1:0] DEV_AUX     = 4'hf;

  localparam logic [WORD_W-1:0] SEL_KEEP_MASK = 32'hffff_0000;

  // Which store the held request reads from.
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_PAL,
    SRC_AUX
  } rd_src_t;

  // Request in flight between the RAM access and the output register.
  typedef struct packed {
    rd_src_t               src;
    logic                  bad_device;
    logic                  colour_valid;
    logic [CINDEX_W-1:0]   colour_index;
    logic [WORD_W-1:0]     colour_argb;
  } pend_t;

  // 5-bit channel to byte: replicate the top bits into the low bits.
  function automatic logic [7:0] expand5(input logic [4:0] c);
    expand5 = {c, c[4:2]};
  endfunction

  // BGR555 (red in bits 4:0) with bit 15 as transparent to ARGB8888.
  function automatic logic [WORD_W-1:0] to_argb(input logic [RDATA_W-1:0] d);
    logic [7:0] a;
    a = d[15] ? 8'h00 : 8'hff;
    to_argb = {a, expand5(d[4:0]), expand5(d[9:5]), expand5(d[14:10])};
  endfunction

endpackage

// ===== sv/prbp_in_if.sv =====
// Input channel: one bus access request per handshake.
interface prbp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [prbp_pkg::OFFSET_W-1:0]  offset;
  logic [prbp_pkg::WORD_W-1:0]    write_data;
  logic [prbp_pkg::WORD_W-1:0]    keep_mask;

  modport source (output valid, mode, offset, write_data, keep_mask, input ready);
  modport sink   (input valid, mode, offset, write_data, keep_mask, output ready);
endinterface

// ===== sv/prbp_out_if.sv =====
// Result channel: one result per accepted access request.
interface prbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [prbp_pkg::RDATA_W-1:0]   read_data;
  logic                           bad_device;
  logic                           colour_valid;
  logic [prbp_pkg::CINDEX_W-1:0]  colour_index;
  logic [prbp_pkg::WORD_W-1:0]    colour_argb;

  modport source (output valid, read_data, bad_device, colour_valid, colour_index,
                  colour_argb, input ready);
  modport sink   (input valid, read_data, bad_device, colour_valid, colour_index,
                  colour_argb, output ready);
endinterface

// ===== sv/prbp_ram.sv =====
// Single-port synchronous RAM with registered read data.
module prbp_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read data only moves on a read, so it holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/palette_ram_bus_port_unit.sv =====
// Top level: bus port into palette RAM and auxiliary RAM.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        mode, offset, write_data, keep_mask
//   out_ch   out  valid/ready        read_data, bad_device, colour_valid,
//                                    colour_index, colour_argb
//
// A request passes the RAM access at the accept edge, which registers the RAM read
// data and the held request, then the output register once that is free.
// Sustained rate is one request per cycle while out_ch does not stall.
// rst_n is synchronous, active low; it clears address, select and valid flags,
// and in_ch is held off while it is asserted.
// RAM contents are not cleared; an entry read before it is written is unknown.
// A stalled output holds the held request, which in turn holds off in_ch.
// Store depths are powers of two; indexes wrap by dropping upper address bits.
`include "assert_macros.svh"

module palette_ram_bus_port_unit #(
  parameter int PALETTE_ENTRIES = 2048,
  parameter int AUX_WORDS       = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  prbp_in_if.sink    in_ch,
  prbp_out_if.source out_ch
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int AUX_AW = $clog2(AUX_WORDS);

  // Architectural registers.
  logic [prbp_pkg::WORD_W-1:0] port_addr_r, port_addr_nxt;
  logic [prbp_pkg::SEL_W-1:0]  dev_sel_r, dev_sel_nxt;

  // Held request waiting on RAM read data.
  logic            pend_r;
  prbp_pkg::pend_t pend_data_r, pend_nxt;

  // Output register.
  logic                          out_valid_r;
  logic [prbp_pkg::RDATA_W-1:0]  out_rdata_r, out_rdata_nxt;
  logic                          out_bad_r;
  logic                          out_cvalid_r;
  logic [prbp_pkg::CINDEX_W-1:0] out_cindex_r;
  logic [prbp_pkg::WORD_W-1:0]   out_argb_r;

  logic in_accept;
  logic pend_go;
  logic is_write;

  // RAM ports.
  logic                        pal_en, pal_we, aux_en, aux_we;
  logic [PAL_AW-1:0]           pal_addr;
  logic [AUX_AW-1:0]           aux_addr;
  logic [prbp_pkg::RDATA_W-1:0] pal_rdata, aux_rdata;

  assign pend_go     = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!pend_r || pend_go);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign is_write    = (in_ch.mode == prbp_pkg::MODE_WRITE);

  // palette is word-addressed at address/2, aux at the address itself
  assign pal_addr = port_addr_r[PAL_AW:1];
  assign aux_addr = port_addr_r[AUX_AW-1:0];

  // Decode the request: register updates, RAM access and result fields.
  always_comb begin
    port_addr_nxt = port_addr_r;
    dev_sel_nxt   = dev_sel_r;
    pal_en        = 1'b0;
    pal_we        = 1'b0;
    aux_en        = 1'b0;
    aux_we        = 1'b0;
    pend_nxt      = '0;
    pend_nxt.src  = prbp_pkg::SRC_NONE;

    unique case (in_ch.offset)
      prbp_pkg::OFF_ADDR: begin
        if (is_write) begin
          port_addr_nxt = (port_addr_r & in_ch.keep_mask) |
                          (in_ch.write_data & ~in_ch.keep_mask);
        end
      end
      prbp_pkg::OFF_SEL: begin
        // select only moves when the whole upper half is written
        if (is_write && ((in_ch.keep_mask & prbp_pkg::SEL_KEEP_MASK) == '0)) begin
          dev_sel_nxt = in_ch.write_data[19:16];
        end
      end
      prbp_pkg::OFF_DATA: begin
        if (dev_sel_r == prbp_pkg::DEV_PALETTE) begin
          pal_en        = in_accept;
          pal_we        = is_write;
          port_addr_nxt = port_addr_r + 32'd2;
          if (is_write) begin
            pend_nxt.colour_valid = 1'b1;
            pend_nxt.colour_index = prbp_pkg::CINDEX_W'(pal_addr);
            pend_nxt.colour_argb  = prbp_pkg::to_argb(in_ch.write_data[15:0]);
          end else begin
            pend_nxt.src = prbp_pkg::SRC_PAL;
          end
        end else if (dev_sel_r == prbp_pkg::DEV_AUX) begin
          aux_en        = in_accept;
          aux_we        = is_write;
          port_addr_nxt = port_addr_r + 32'd1;
          if (!is_write) begin
            pend_nxt.src = prbp_pkg::SRC_AUX;
          end
        end else begin
          // unknown device: flag it; a write still steps the address
          pend_nxt.bad_device = 1'b1;
          if (is_write) begin
            port_addr_nxt = port_addr_r + 32'd1;
          end
        end
      end
      default: begin
        // unused offset: no effect, all-zero result
      end
    endcase
  end

  prbp_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH (prbp_pkg::RDATA_W)
  ) u_pal_ram (
    .clk   (clk),
    .en    (pal_en),
    .we    (pal_we),
    .addr  (pal_addr),
    .wdata (in_ch.write_data[15:0]),
    .rdata (pal_rdata)
  );

  prbp_ram #(
    .DEPTH (AUX_WORDS),
    .WIDTH (prbp_pkg::RDATA_W)
  ) u_aux_ram (
    .clk   (clk),
    .en    (aux_en),
    .we    (aux_we),
    .addr  (aux_addr),
    .wdata (in_ch.write_data[15:0]),
    .rdata (aux_rdata)
  );

  // Pick read data for the held request.
  always_comb begin
    case (pend_data_r.src)
      prbp_pkg::SRC_PAL: out_rdata_nxt = pal_rdata;
      prbp_pkg::SRC_AUX: out_rdata_nxt = aux_rdata;
      default:           out_rdata_nxt = '0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_addr_r <= '0;
      dev_sel_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        port_addr_r <= port_addr_nxt;
        dev_sel_r   <= dev_sel_nxt;
      end
      if (in_accept) begin
        pend_r <= 1'b1;
      end else if (pend_go) begin
        pend_r <= 1'b0;
      end
      if (pend_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_data_r <= pend_nxt;
    end
    if (pend_go) begin
      out_rdata_r  <= out_rdata_nxt;
      out_bad_r    <= pend_data_r.bad_device;
      out_cvalid_r <= pend_data_r.colour_valid;
      out_cindex_r <= pend_data_r.colour_index;
      out_argb_r   <= pend_data_r.colour_argb;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rdata_r;
  assign out_ch.bad_device   = out_bad_r;
  assign out_ch.colour_valid = out_cvalid_r;
  assign out_ch.colour_index = out_cindex_r;
  assign out_ch.colour_argb  = out_argb_r;

  // Palette data access steps the address by two.
  `ASSERT_NXT(a_pal_step, clk, rst_n, in_accept && (in_ch.offset == prbp_pkg::OFF_DATA) && (dev_sel_r == prbp_pkg::DEV_PALETTE), port_addr_r == $past(port_addr_r) + 32'd2, "palette access did not step address by 2")

  // A held request that cannot drain blocks new requests.
  `ASSERT_IMP(a_hold_blocks, clk, rst_n, pend_r && out_valid_r && !out_ch.ready, !in_ch.ready, "request accepted over a stalled held request")

  // A colour report never comes with a RAM read or a device error.
  `ASSERT_IMP(a_colour_clean, clk, rst_n, pend_r && pend_data_r.colour_valid, !pend_data_r.bad_device && (pend_data_r.src == prbp_pkg::SRC_NONE), "colour report mixed with read or error")

endmodule

// ===== sim/tb_palette_ram_bus_port_unit.sv =====
// Self-checking testbench for the palette / auxiliary RAM bus port.
module tb_palette_ram_bus_port_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import prbp_pkg::*;

  // Store depths match the DUT build below; index widths follow from them.
  localparam int PAL_ENTRIES = 2048;
  localparam int AUX_DEPTH   = 4096;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
  localparam int AUX_IDX_W   = $clog2(AUX_DEPTH);

  localparam int HALF_PERIOD  = 4;     // 8 ns clock
  localparam int RANDOM_ITEMS = 1750;  // random requests that reach a register or the port
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either channel
  localparam int DRAIN_CYCLES = 16;    // quiet spell at the end; leave room for stragglers
  localparam int REPORT_MAX   = 10;

  localparam logic                MODE_READ  = ~MODE_WRITE;
  localparam logic [OFFSET_W-1:0] OFF_UNUSED = 2'd3;

  // One bus access request and the result it produces.
  typedef struct packed {
    logic                mode;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]   write_data;
    logic [WORD_W-1:0]   keep_mask;
  } access_t;

  typedef struct packed {
    logic [RDATA_W-1:0]  read_data;
    logic                bad_device;
    logic                colour_valid;
    logic [CINDEX_W-1:0] colour_index;
    logic [WORD_W-1:0]   colour_argb;
  } result_t;

  // Directed row: the request, and a hand-written result where one is given.
  typedef struct packed {
    access_t acc;
    bit      typed;
    result_t res;
  } row_t;

  localparam bit      TYPED     = 1'b1;
  localparam bit      PREDICTED = 1'b0;
  localparam result_t ZERO_RES  = '0;
  localparam result_t BAD_RES   = {16'h0000, 1'b1, 1'b0, 11'd0, 32'h0};

  // Directed part. Address and select are tracked in the notes above the rows.
  localparam int N_DIRECTED = 27;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // register reads after reset give an all-zero result
    {MODE_READ,  OFF_ADDR,   32'h0000_0000, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_READ,  OFF_SEL,    32'h0000_0000, 32'h0000_0000, TYPED, ZERO_RES},
    // select 0 is unknown: read leaves the address, write bumps it to 1
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED, BAD_RES},
    {MODE_WRITE, OFF_DATA,   32'hffff_ffff, 32'h0000_0000, TYPED, BAD_RES},
    // unused offset, both directions
    {MODE_WRITE, OFF_UNUSED, 32'hffff_ffff, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_READ,  OFF_UNUSED, 32'hffff_ffff, 32'hffff_ffff, TYPED, ZERO_RES},
    // address write with every bit kept: still 1
    {MODE_WRITE, OFF_ADDR,   32'hffff_ffff, 32'hffff_ffff, TYPED, ZERO_RES},
    // address -> ffff_fffe
    {MODE_WRITE, OFF_ADDR,   32'hffff_fffe, 32'h0000_0000, TYPED, ZERO_RES},
    // select write with an upper keep bit set is dropped; select stays unknown
    {MODE_WRITE, OFF_SEL,    32'h000d_0000, 32'h0001_0000, TYPED, ZERO_RES},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED, BAD_RES},
    // select palette; lower keep bits do not matter
    {MODE_WRITE, OFF_SEL,    32'h000d_0000, 32'h0000_ffff, TYPED, ZERO_RES},
    // top palette entry, all ones: transparent white; address wraps to 0
    {MODE_WRITE, OFF_DATA,   32'h0000_ffff, 32'h0000_0000, TYPED,
     {16'h0000, 1'b0, 1'b1, 11'd2047, 32'h00ff_ffff}},
    // upper data bits ignored: entry 0 gets zero, opaque black
    {MODE_WRITE, OFF_DATA,   32'hffff_0000, 32'h0000_0000, TYPED,
     {16'h0000, 1'b0, 1'b1, 11'd0, 32'hff00_0000}},
    // entry 1: red and blue full, green zero
    {MODE_WRITE, OFF_DATA,   32'h0000_7c1f, 32'h0000_0000, PREDICTED, ZERO_RES},
    // back to ffff_fffe and read entries 2047, 0, 1
    {MODE_WRITE, OFF_ADDR,   32'hffff_fffe, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED,
     {16'hffff, 1'b0, 1'b0, 11'd0, 32'h0}},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, PREDICTED, ZERO_RES},
    // select aux, address ffff_ffff: aux index 4095 then wrap to 0
    {MODE_WRITE, OFF_SEL,    32'h000f_0000, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_WRITE, OFF_ADDR,   32'hffff_ffff, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_WRITE, OFF_DATA,   32'h1234_abcd, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_WRITE, OFF_DATA,   32'h0000_ffff, 32'h0000_0000, TYPED, ZERO_RES},
    // mixed keep: bit 0 kept from address 1, rest from data -> ffff_ffff
    {MODE_WRITE, OFF_ADDR,   32'hffff_fffe, 32'h0000_0001, TYPED, ZERO_RES},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED,
     {16'habcd, 1'b0, 1'b0, 11'd0, 32'h0}},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED,
     {16'hffff, 1'b0, 1'b0, 11'd0, 32'h0}},
    // unknown select again
    {MODE_WRITE, OFF_SEL,    32'h0007_0000, 32'h0000_0000, TYPED, ZERO_RES},
    {MODE_READ,  OFF_DATA,   32'h0000_0000, 32'h0000_0000, TYPED, BAD_RES}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  prbp_in_if  in_ch();
  prbp_out_if out_ch();

  palette_ram_bus_port_unit #(
    .PALETTE_ENTRIES(PAL_ENTRIES),
    .AUX_WORDS      (AUX_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the port: address, select and both stores. The written flags
  // keep the stimulus from reading an entry that holds nothing defined.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]  addr_reg = '0;
  logic [SEL_W-1:0]   sel_reg  = '0;
  logic [RDATA_W-1:0] pal_mem     [PAL_ENTRIES];
  logic [RDATA_W-1:0] aux_mem     [AUX_DEPTH];
  bit                 pal_written [PAL_ENTRIES];
  bit                 aux_written [AUX_DEPTH];

  result_t response_q [$];   // results still owed by the DUT, oldest first
  access_t plan_q     [$];   // random requests lined up but not yet sent

  int unsigned n_pal_wr, n_pal_rd, n_aux_wr, n_aux_rd, n_bad, n_reg;
  int unsigned n_checked, mismatches;
  int unsigned burst_left;

  // 5-bit channel to a full byte: shift up, refill the low bits from the top.
  function automatic logic [7:0] chan8(input logic [4:0] c);
    logic [7:0] w;
    w = {3'b000, c};
    return (w << 3) | (w >> 2);
  endfunction

  // Applies one accepted request to the shadow state and returns its result.
  task automatic port_access(input access_t a, output result_t r);
    logic [PAL_IDX_W-1:0] pidx;
    logic [AUX_IDX_W-1:0] aidx;
    logic [RDATA_W-1:0]   word;
    r    = '0;
    pidx = addr_reg[1 +: PAL_IDX_W];        // palette holds 16-bit words at even bytes
    aidx = addr_reg[AUX_IDX_W-1:0];
    word = a.write_data[RDATA_W-1:0];       // bits above 15 never reach a store
    case (a.offset)
      OFF_ADDR: begin
        if (a.mode == MODE_WRITE)
          addr_reg = (addr_reg & a.keep_mask) | (a.write_data & ~a.keep_mask);
        n_reg++;
      end
      OFF_SEL: begin
        // select only moves when the whole upper half is being written
        if (a.mode == MODE_WRITE && (a.keep_mask & SEL_KEEP_MASK) == '0)
          sel_reg = a.write_data[16 +: SEL_W];
        n_reg++;
      end
      OFF_DATA: begin
        if (sel_reg == DEV_PALETTE) begin
          if (a.mode == MODE_WRITE) begin
            pal_mem[pidx]     = word;
            pal_written[pidx] = 1'b1;
            r.colour_valid    = 1'b1;
            r.colour_index    = pidx;
            r.colour_argb     = {word[15] ? 8'h00 : 8'hff, chan8(word[4:0]),
                                 chan8(word[9:5]), chan8(word[14:10])};
            n_pal_wr++;
          end else begin
            r.read_data = pal_mem[pidx];
            n_pal_rd++;
          end
          addr_reg = addr_reg + 32'd2;
        end else if (sel_reg == DEV_AUX) begin
          if (a.mode == MODE_WRITE) begin
            aux_mem[aidx]     = word;
            aux_written[aidx] = 1'b1;
            n_aux_wr++;
          end else begin
            r.read_data = aux_mem[aidx];
            n_aux_rd++;
          end
          addr_reg = addr_reg + 32'd1;
        end else begin
          // unknown device: flag it; only a write moves the address
          r.bad_device = 1'b1;
          if (a.mode == MODE_WRITE)
            addr_reg = addr_reg + 32'd1;
          n_bad++;
        end
      end
      default: ;  // unused offset: no effect, all-zero result
    endcase
  endtask

  task automatic queue_request(input logic m, input logic [OFFSET_W-1:0] o,
                               input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] k);
    access_t a;
    a = {m, o, d, k};
    plan_q.push_back(a);
  endtask

  // Sends one request, called at a falling edge. Between bursts the sender
  // may drop valid for a random gap. On acceptance the shadow is updated
  // right away so the next request is shaped on current state.
  task automatic drive_request(input access_t a, input bit typed, input result_t want);
    result_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= a.mode;
    in_ch.offset     <= a.offset;
    in_ch.write_data <= a.write_data;
    in_ch.keep_mask  <= a.keep_mask;
    do @(posedge clk); while (!in_ch.ready);
    port_access(a, r);
    response_q.push_back(typed ? want : r);
    burst_left--;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: phases of always-ready, a repeating 16-slot pattern (bit 0 forced
  // so a stall never spans a whole turn), and heavy random stalls.
  // ---------------------------------------------------------------------------
  logic        sink_ready    = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned stall_kind    = 0;
  logic [15:0] stall_pattern = 16'hffff;

  assign out_ch.ready = sink_ready;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind    <= $urandom_range(0, 2);
      stall_left    <= $urandom_range(24, 160);
      stall_pattern <= 16'($urandom) | 16'h0001;
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      0:       sink_ready <= 1'b1;
      1:       sink_ready <= stall_pattern[stall_left[3:0]];
      default: sink_ready <= ($urandom_range(0, 99) >= 60);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.read_data, out_ch.bad_device, out_ch.colour_valid,
             out_ch.colour_index, out_ch.colour_argb};
      if (response_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: rd=%h bad=%b cv=%b idx=%0d argb=%h",
                   got.read_data, got.bad_device, got.colour_valid,
                   got.colour_index, got.colour_argb);
      end else begin
        want = response_q.pop_front();
        n_checked++;
        if (got.read_data !== want.read_data || got.bad_device !== want.bad_device ||
            got.colour_valid !== want.colour_valid ||
            got.colour_index !== want.colour_index ||
            got.colour_argb !== want.colour_argb) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result %0d mismatch", n_checked);
            $display("  expected rd=%h bad=%b cv=%b idx=%0d argb=%h",
                     want.read_data, want.bad_device, want.colour_valid,
                     want.colour_index, want.colour_argb);
            $display("  actual   rd=%h bad=%b cv=%b idx=%0d argb=%h",
                     got.read_data, got.bad_device, got.colour_valid,
                     got.colour_index, got.colour_argb);
          end
        end
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either channel is a hang.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, response_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random sequences until enough requests
  // that touch a register or the data port have gone in.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    access_t          a;
    logic [SEL_W-1:0] dev;
    logic [WORD_W-1:0] base;
    int unsigned      run_len;
    int unsigned      counted;

    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_READ;
    in_ch.offset     <= OFF_ADDR;
    in_ch.write_data <= '0;
    in_ch.keep_mask  <= '0;
    counted          = 0;
    burst_left       = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      drive_request(DIRECTED[i].acc, DIRECTED[i].typed, DIRECTED[i].res);

    while (counted < RANDOM_ITEMS) begin
      if (plan_q.size() == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Write a run into one store, rewind, read it back with a few
            // writes mixed in. Bases favor both ends of the address space.
            dev = $urandom_range(0, 1) ? DEV_PALETTE : DEV_AUX;
            case ($urandom_range(0, 3))
              0:       base = $urandom;
              1:       base = 32'hffff_ffff - $urandom_range(0, 24);
              2:       base = $urandom_range(0, 40);
              default: base = $urandom & 32'h0000_1fff;
            endcase
            run_len = $urandom_range(1, 12);
            queue_request(MODE_WRITE, OFF_SEL, ($urandom & 32'hfff0_ffff) | (32'(dev) << 16),
                          $urandom & ~SEL_KEEP_MASK);
            queue_request(MODE_WRITE, OFF_ADDR, base, 32'h0);
            repeat (run_len) queue_request(MODE_WRITE, OFF_DATA, $urandom, $urandom);
            queue_request(MODE_WRITE, OFF_ADDR, base, 32'h0);
            repeat (run_len)
              queue_request(($urandom_range(0, 4) == 0) ? MODE_WRITE : MODE_READ, OFF_DATA,
                            $urandom, $urandom);
          end
          4: begin
            // noise: any kind, any offset, any mask
            repeat ($urandom_range(1, 6))
              queue_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            $urandom, $urandom);
          end
          5: begin
            // unknown device, then a select write that must be dropped
            do dev = 4'($urandom_range(0, 15)); while (dev == DEV_PALETTE || dev == DEV_AUX);
            queue_request(MODE_WRITE, OFF_SEL, 32'(dev) << 16, 32'h0);
            repeat ($urandom_range(1, 5))
              queue_request(1'($urandom_range(0, 1)), OFF_DATA, $urandom, $urandom);
            queue_request(MODE_WRITE, OFF_SEL, $urandom,
                          $urandom | (32'h0001_0000 << $urandom_range(0, 15)));
          end
          6: begin
            repeat ($urandom_range(1, 4))
              queue_request(MODE_READ, $urandom_range(0, 1) ? OFF_ADDR : OFF_SEL,
                            $urandom, $urandom);
          end
          default: begin
            // port traffic from wherever the address stands
            if ($urandom_range(0, 1))
              queue_request(MODE_WRITE, OFF_ADDR, $urandom, $urandom);
            repeat ($urandom_range(1, 10))
              queue_request(1'($urandom_range(0, 1)), OFF_DATA, $urandom, $urandom);
          end
        endcase
      end
      a = plan_q.pop_front();
      // a read of a never-written entry becomes a write to it
      if (a.offset == OFF_DATA && a.mode == MODE_READ &&
          ((sel_reg == DEV_PALETTE && !pal_written[addr_reg[1 +: PAL_IDX_W]]) ||
           (sel_reg == DEV_AUX && !aux_written[addr_reg[AUX_IDX_W-1:0]])))
        a.mode = MODE_WRITE;
      drive_request(a, PREDICTED, ZERO_RES);
      if (a.offset != OFF_UNUSED)
        counted++;
    end
    in_ch.valid <= 1'b0;

    // wait out owed results, then a quiet spell to catch anything extra
    while (response_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d palette writes, %0d palette reads, %0d aux writes, %0d aux reads",
             n_pal_wr, n_pal_rd, n_aux_wr, n_aux_rd);
    $display("covered: %0d unknown-device accesses, %0d register accesses, %0d results, %0d bad",
             n_bad, n_reg, n_checked, mismatches);
    if (mismatches == 0 && response_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
